FILE: hdl/anb_pkg.sv
// ----------------------------------------------------------------------------
// anb_pkg
// Shared constants and types for the Annex B unit splitter.
// ----------------------------------------------------------------------------
package anb_pkg;

    // Capacity of one buffer in bytes; positions and sizes saturate here.
    localparam int unsigned BUFFER_BYTES = 4194304;

    localparam int unsigned OFFSET_W = 22;
    localparam int unsigned SIZE_W   = 23;
    localparam int unsigned TYPE_W   = 5;
    localparam int unsigned ZRUN_W   = 2;

    localparam logic [7:0]        START_BYTE = 8'h01;
    localparam logic [7:0]        ZERO_BYTE  = 8'h00;
    localparam logic [ZRUN_W-1:0] ZRUN_MAX   = 2'd3;
    localparam logic [ZRUN_W-1:0] ZRUN_MIN   = 2'd2;

    localparam logic [SIZE_W-1:0]   BUF_LIMIT = SIZE_W'(BUFFER_BYTES);
    localparam logic [OFFSET_W-1:0] OFF_LAST  = OFFSET_W'(BUFFER_BYTES - 1);

    typedef struct packed {
        logic [OFFSET_W-1:0] unit_offset;
        logic [SIZE_W-1:0]   unit_size;
        logic [TYPE_W-1:0]   unit_type;
        logic                closed_by_end;
    } t_unit;

    typedef struct packed {
        logic  valid;
        t_unit unit;
    } t_parse_out;

endpackage

FILE: hdl/anb_parse.sv
// ----------------------------------------------------------------------------
// anb_parse
// Start code tracking state and the per-byte unit result.
// ----------------------------------------------------------------------------
module anb_parse
    import anb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_data_byte,
    input  logic       i_end_of_buffer,
    output t_parse_out o_result
);

    logic [ZRUN_W-1:0]   r_zrun, n_zrun;
    logic [SIZE_W-1:0]   r_pos, n_pos;
    logic                r_open, n_open;
    logic                r_hdr, n_hdr;
    logic [OFFSET_W-1:0] r_off, n_off;
    logic [TYPE_W-1:0]   r_type, n_type;

    logic                eff_open;
    logic [OFFSET_W-1:0] eff_off;
    logic [TYPE_W-1:0]   eff_type;
    logic                code_done;
    logic [SIZE_W-1:0]   back;
    logic [SIZE_W-1:0]   start;
    logic [SIZE_W-1:0]   off_ext;
    logic [SIZE_W-1:0]   size_code;
    logic [SIZE_W:0]     size_end_raw;
    logic [SIZE_W-1:0]   size_end;

    always_comb begin
        // A header byte opens the unit in the same cycle.
        eff_open = r_open | r_hdr;
        if (r_hdr) begin
            eff_off  = (r_pos >= BUF_LIMIT) ? OFF_LAST : r_pos[OFFSET_W-1:0];
            eff_type = i_data_byte[TYPE_W-1:0];
        end else begin
            eff_off  = r_off;
            eff_type = r_type;
        end
        off_ext = {1'b0, eff_off};

        code_done = (i_data_byte == START_BYTE) && (r_zrun >= ZRUN_MIN);
        back      = (r_zrun == ZRUN_MAX) ? SIZE_W'(3) : SIZE_W'(2);
        start     = (r_pos >= back) ? r_pos - back : '0;
        size_code = (start > off_ext) ? start - off_ext : '0;

        size_end_raw = (r_pos >= off_ext) ? ({1'b0, r_pos} - {1'b0, off_ext} + (SIZE_W+1)'(1))
                                          : '0;
        size_end     = (size_end_raw > {1'b0, BUF_LIMIT}) ? BUF_LIMIT
                                                          : size_end_raw[SIZE_W-1:0];

        o_result                    = '0;
        o_result.unit.unit_offset   = eff_off;
        o_result.unit.unit_type     = eff_type;
        if (code_done) begin
            o_result.valid              = i_accept && eff_open;
            o_result.unit.unit_size     = size_code;
            o_result.unit.closed_by_end = 1'b0;
        end else begin
            o_result.valid              = i_accept && eff_open && i_end_of_buffer;
            o_result.unit.unit_size     = size_end;
            o_result.unit.closed_by_end = 1'b1;
        end

        if (i_data_byte == ZERO_BYTE) begin
            n_zrun = (r_zrun == ZRUN_MAX) ? r_zrun : r_zrun + ZRUN_W'(1);
        end else begin
            n_zrun = '0;
        end
        n_open = code_done ? 1'b0 : eff_open;
        n_hdr  = code_done;
        n_off  = eff_off;
        n_type = eff_type;
        n_pos  = (r_pos < BUF_LIMIT) ? r_pos + SIZE_W'(1) : r_pos;

        // The last byte of a buffer returns everything to the reset state.
        if (i_end_of_buffer) begin
            n_zrun = '0;
            n_open = 1'b0;
            n_hdr  = 1'b0;
            n_off  = '0;
            n_type = '0;
            n_pos  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zrun <= '0;
            r_pos  <= '0;
            r_open <= 1'b0;
            r_hdr  <= 1'b0;
            r_off  <= '0;
            r_type <= '0;
        end else if (i_accept) begin
            r_zrun <= n_zrun;
            r_pos  <= n_pos;
            r_open <= n_open;
            r_hdr  <= n_hdr;
            r_off  <= n_off;
            r_type <= n_type;
        end
    end

endmodule

FILE: hdl/annexb_nal_unit_splitter.sv
// ----------------------------------------------------------------------------
// annexb_nal_unit_splitter
// Splits an H.264 Annex B byte stream into units at its start codes.
// ----------------------------------------------------------------------------
// The block takes one byte per request, flagged on the last byte of each
// buffer, and finds the start codes 00 00 01 and 00 00 00 01 (three or more
// zeros before the 01 make a four-byte code; further zeros stay with the
// previous unit). Each unit is reported once, when the following start code
// completes or when the buffer ends, with the position of its header byte, its
// size without the start code, its type (header byte AND 0x1f) and whether the
// buffer end closed it. Bytes before the first start code are dropped, and a
// start code on the last byte closes the previous unit without opening an
// empty one. The parser state is updated in the cycle of acceptance and any
// result lands in an output register in the same cycle, so a byte can be
// accepted in every cycle while the skid register is empty. A skid register
// behind the output register lets input continue for one further result while
// the consumer stalls; input pauses only when both hold a result. Positions
// and sizes saturate at the buffer capacity.
// ----------------------------------------------------------------------------
module annexb_nal_unit_splitter
    import anb_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [7:0]          i_data_byte,
    input  logic                i_end_of_buffer,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [OFFSET_W-1:0] o_unit_offset,
    output logic [SIZE_W-1:0]   o_unit_size,
    output logic [TYPE_W-1:0]   o_unit_type,
    output logic                o_closed_by_end
);

    logic       accept;
    logic       take;
    t_parse_out parse_res;

    logic  r_out_valid;
    t_unit r_out;
    logic  r_skid_valid;
    t_unit r_skid;

    // The input is held off only while both the output and skid registers
    // are occupied, so no result can ever be lost.
    assign o_ready = !r_skid_valid;
    assign accept  = i_valid && o_ready;
    assign take    = r_out_valid && i_ready;

    anb_parse u_parse (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_data_byte     (i_data_byte),
        .i_end_of_buffer (i_end_of_buffer),
        .o_result        (parse_res)
    );

    // Output register with a skid stage. A new result goes straight to the
    // output register when it is free or is being emptied this cycle, and to
    // the skid register otherwise.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (take) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (parse_res.valid) begin
            if (!r_out_valid || take) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (take) begin
                r_out <= r_skid;
            end
        end else if (parse_res.valid) begin
            if (!r_out_valid || take) begin
                r_out <= parse_res.unit;
            end else begin
                r_skid <= parse_res.unit;
            end
        end
    end

    assign o_valid         = r_out_valid;
    assign o_unit_offset   = r_out.unit_offset;
    assign o_unit_size     = r_out.unit_size;
    assign o_unit_type     = r_out.unit_type;
    assign o_closed_by_end = r_out.closed_by_end;

    // The skid register is only ever filled behind a full output register.
    a_skid_behind_out : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register holds a result while the output is empty");

    // A unit closed by the buffer end always contains at least its header.
    a_end_unit_nonempty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.closed_by_end) |-> (r_out.unit_size != '0))
        else $error("unit closed by buffer end reported with size zero");

    // Sizes never exceed the buffer capacity.
    a_size_bounded : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        parse_res.valid |-> (parse_res.unit.unit_size <= BUF_LIMIT))
        else $error("unit size beyond buffer capacity");

    // A result produced while the skid is full would be lost.
    a_no_push_when_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> !parse_res.valid)
        else $error("result produced while both output stages are full");

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the Annex B start-code unit splitter.
// ----------------------------------------------------------------------------
// Byte requests are queued by the stimulus process and presented by a clocked
// driver. The driver updates a software copy of the parser on every accepted
// request. The clocked monitor checks each reported unit field by field
// against the oldest prediction. The run has four phases with different
// amounts of sender idling and receiver stalling. It opens with hand-written
// buffers, then mostly well-formed random streams with some noise buffers.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import anb_pkg::*;

    // One queued byte request: the data byte and the end-of-buffer flag.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_byte_req;

    logic                i_clk           = 1'b0;
    logic                i_rst_n         = 1'b0;
    logic                i_valid         = 1'b0;
    logic [7:0]          i_data_byte     = 8'h00;
    logic                i_end_of_buffer = 1'b0;
    logic                i_ready         = 1'b0;
    logic                o_ready;
    logic                o_valid;
    logic [OFFSET_W-1:0] o_unit_offset;
    logic [SIZE_W-1:0]   o_unit_size;
    logic [TYPE_W-1:0]   o_unit_type;
    logic                o_closed_by_end;

    annexb_nal_unit_splitter u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_data_byte     (i_data_byte),
        .i_end_of_buffer (i_end_of_buffer),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_unit_offset   (o_unit_offset),
        .o_unit_size     (o_unit_size),
        .o_unit_type     (o_unit_type),
        .o_closed_by_end (o_closed_by_end)
    );

    // Requests waiting for the driver, and units the parser copy has reported
    // but the block has not yet delivered.
    t_byte_req   pending_bytes[$];
    t_unit       expected_units[$];
    logic [7:0]  build_q[$];
    t_byte_req   next_req;
    t_unit       want_unit;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned error_count    = 0;
    int unsigned queued_count   = 0;

    // Software copy of the parser state.
    logic [ZRUN_W-1:0]   zero_run;
    logic [SIZE_W-1:0]   byte_position;
    logic                unit_open;
    logic                header_expected;
    logic [OFFSET_W-1:0] open_unit_offset;
    logic [TYPE_W-1:0]   open_unit_type;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Generous ceiling on the run; a correct run finishes far sooner.
    initial begin
        #5_000_000;
        $display("annexb_nal_unit_splitter test failed");
        $finish;
    end

    task automatic report(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic clear_parser();
        zero_run         = '0;
        byte_position    = '0;
        unit_open        = 1'b0;
        header_expected  = 1'b0;
        open_unit_offset = '0;
        open_unit_type   = '0;
    endtask

    // Adds one byte to the buffer being built.
    task automatic append_byte(input logic [7:0] b);
        build_q = {build_q, b};
    endtask

    // Records the open unit as a prediction, with its size clipped to the
    // buffer capacity.
    task automatic predict_unit(input int unsigned size, input logic by_end);
        t_unit u;
        u.unit_offset   = open_unit_offset;
        u.unit_size     = SIZE_W'((size > BUFFER_BYTES) ? BUFFER_BYTES : size);
        u.unit_type     = open_unit_type;
        u.closed_by_end = by_end;
        expected_units  = {expected_units, u};
    endtask

    // Advances the parser copy by one accepted byte.
    task automatic split_byte(input logic [7:0] b, input logic last);
        int unsigned pos;
        int unsigned back;
        int unsigned start_pos;
        bit          code_done;
        pos       = byte_position;
        code_done = 0;

        // The byte after a start code is the header of a new unit.
        if (header_expected) begin
            open_unit_offset = (pos >= BUFFER_BYTES) ? OFF_LAST : OFFSET_W'(pos);
            open_unit_type   = b[TYPE_W-1:0];
            unit_open        = 1'b1;
            header_expected  = 1'b0;
        end

        // A 01 after two zeros completes a three-byte code; after three or
        // more it completes a four-byte one, the extra zeros staying behind.
        if (b == START_BYTE && zero_run >= ZRUN_MIN) begin
            back      = (zero_run == ZRUN_MAX) ? 3 : 2;
            start_pos = (pos >= back) ? pos - back : 0;
            code_done = 1;
            if (unit_open) begin
                predict_unit((start_pos > open_unit_offset) ?
                             start_pos - open_unit_offset : 0, 1'b0);
            end
            unit_open       = 1'b0;
            header_expected = 1'b1;
        end

        if (b == ZERO_BYTE) begin
            if (zero_run != ZRUN_MAX) zero_run = zero_run + 1'b1;
        end else begin
            zero_run = '0;
        end

        // The buffer end closes an open unit unless a start code ended on
        // this very byte, and the next byte starts a fresh buffer.
        if (last) begin
            if (!code_done && unit_open) begin
                predict_unit((pos >= open_unit_offset) ?
                             pos - open_unit_offset + 1 : 0, 1'b1);
            end
            clear_parser();
        end else if (byte_position < BUF_LIMIT) begin
            byte_position = byte_position + 1'b1;
        end
    endtask

    // Moves the bytes gathered in build_q to the request queue as one buffer.
    task automatic close_buffer();
        t_byte_req r;
        foreach (build_q[i]) begin
            r.data = build_q[i];
            r.last = (i == build_q.size() - 1);
            pending_bytes = {pending_bytes, r};
        end
        queued_count += build_q.size();
        build_q.delete();
    endtask

    task automatic add_zeros(input int unsigned n);
        repeat (n) append_byte(ZERO_BYTE);
    endtask

    // A well-formed buffer: optional leading junk, one to four units each
    // behind a start code, and a random kind of ending.
    task automatic add_stream_buffer();
        int unsigned n_units;
        int unsigned n_zeros;
        int unsigned ending;
        n_units = $urandom_range(1, 4);
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 4)) append_byte(8'($urandom));
        end
        repeat (n_units) begin
            n_zeros = $urandom_range(2, 3);
            if ($urandom_range(0, 7) == 0) n_zeros += $urandom_range(1, 3);
            add_zeros(n_zeros);
            append_byte(START_BYTE);
            append_byte(($urandom_range(0, 15) == 0) ? ZERO_BYTE : 8'($urandom));
            repeat ($urandom_range(0, 12)) begin
                append_byte(($urandom_range(0, 3) == 0) ? ZERO_BYTE : 8'($urandom));
            end
        end
        ending = $urandom_range(0, 5);
        if (ending == 0) begin
            // The buffer ends exactly on a start code.
            add_zeros($urandom_range(2, 3));
            append_byte(START_BYTE);
        end else if (ending == 1) begin
            add_zeros($urandom_range(1, 3));
        end
        close_buffer();
    endtask

    // A buffer of arbitrary bytes.
    task automatic add_noise_buffer();
        repeat ($urandom_range(1, 10)) begin
            append_byte(($urandom_range(0, 2) == 0) ?
                        8'($urandom_range(0, 1)) : 8'($urandom));
        end
        close_buffer();
    endtask

    task automatic add_directed();
        // Leading junk, a three-byte code, a four-byte code, a code with an
        // extra zero kept by the unit before it, and a code on the last byte.
        build_q = '{8'hAA, 8'h00, 8'h00, 8'h01, 8'h67, 8'h42,
                    8'h00, 8'h00, 8'h00, 8'h01, 8'h68, 8'hCE,
                    8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h65, 8'hFF,
                    8'h00, 8'h00, 8'h01};
        close_buffer();
        // A zero header that feeds the next code, giving an empty unit, then
        // a header on the last byte.
        build_q = '{8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h01, 8'hFF};
        close_buffer();
        // A single-byte buffer with no start code at all.
        build_q = '{8'h01};
        close_buffer();
    endtask

    task automatic wait_requests_sent();
        while (pending_bytes.size() != 0 || i_valid) @(posedge i_clk);
    endtask

    // Driver: the parser copy sees each request as it is accepted, and a new
    // request is offered only once the previous one has gone.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) split_byte(i_data_byte, i_end_of_buffer);
            if (!i_valid || o_ready) begin
                if (pending_bytes.size() != 0 &&
                    $urandom_range(0, 99) >= send_idle_pct) begin
                    next_req         = pending_bytes.pop_front();
                    i_valid         <= 1'b1;
                    i_data_byte     <= next_req.data;
                    i_end_of_buffer <= next_req.last;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: random back-pressure, and a field-by-field check of each unit.
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_units.size() == 0) begin
                report($sformatf("unexpected unit offset %0d size %0d type %0d",
                                 o_unit_offset, o_unit_size, o_unit_type));
            end else begin
                want_unit = expected_units.pop_front();
                if (o_unit_offset !== want_unit.unit_offset)
                    report($sformatf("unit_offset %0d, expected %0d",
                                     o_unit_offset, want_unit.unit_offset));
                if (o_unit_size !== want_unit.unit_size)
                    report($sformatf("unit_size %0d, expected %0d",
                                     o_unit_size, want_unit.unit_size));
                if (o_unit_type !== want_unit.unit_type)
                    report($sformatf("unit_type %0d, expected %0d",
                                     o_unit_type, want_unit.unit_type));
                if (o_closed_by_end !== want_unit.closed_by_end)
                    report($sformatf("closed_by_end %0b, expected %0b",
                                     o_closed_by_end, want_unit.closed_by_end));
            end
        end
    end

    initial begin
        clear_parser();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Phases: free flow, idle sender, stalling receiver, both together.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                    add_directed();
                end
                1: begin
                    send_idle_pct  = 67;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 67;
                end
                default: begin
                    send_idle_pct  = 23;
                    recv_stall_pct = 23;
                end
            endcase
            while (queued_count < (phase + 1) * 1250 / 4) begin
                if ($urandom_range(0, 9) < 8) add_stream_buffer();
                else add_noise_buffer();
            end
            wait_requests_sent();
        end

        while (expected_units.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (error_count == 0) begin
            $display("annexb_nal_unit_splitter test passed");
        end else begin
            $display("annexb_nal_unit_splitter test failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
hdl/anb_pkg.sv
hdl/anb_parse.sv
hdl/annexb_nal_unit_splitter.sv
tb/testbench.sv
